FILE: hw/rtl/ppba_pkg.sv
// ----------------------------------------------------------------------------
// ppba_pkg
// Shared types, operation codes and helpers for the page bitmap allocator.
// ----------------------------------------------------------------------------
package ppba_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int OS_W      = 10;
  localparam int PAGE_W    = 9;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t TOP_BIT  = 32'h8000_0000;
  localparam word_t ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_OS_PAGES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_PAGE = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_PAGE = 1'b1;

  typedef struct packed {
    logic              status;
    logic [PAGE_W-1:0] page;
  } rsp_t;

  // Position of the first set bit counting from the MSB (lowest page first)
  function automatic logic [BIT_W-1:0] first_free(word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) begin
        idx = BIT_W'(WORD_BITS - 1 - i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: hw/rtl/ppba_map_ram.sv
// ----------------------------------------------------------------------------
// ppba_map_ram
// Free map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppba_map_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  ppba_pkg::word_t   wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output ppba_pkg::word_t   rdata
);
  import ppba_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ppba_ctrl.sv
// ----------------------------------------------------------------------------
// ppba_ctrl
// Request sequencer: word scan for allocate, read-modify-write for free and
// a one-word-per-cycle rebuild sweep for init and after reset.
// ----------------------------------------------------------------------------
module ppba_ctrl #(
  parameter int MAX_PAGES = 512,
  parameter int ADDR_W    = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [ppba_pkg::OP_W-1:0]     req_op,
  input  logic [ppba_pkg::PAGE_W-1:0]   req_page,
  input  logic [ppba_pkg::OS_W-1:0]     os_pages,
  input  logic [ppba_pkg::PAGE_W-1:0]   last_page,
  input  logic                          slot_free,
  output logic                          fin_valid,
  output ppba_pkg::rsp_t                fin_rsp,
  output logic                          ram_we,
  output logic [ADDR_W-1:0]             ram_waddr,
  output ppba_pkg::word_t               ram_wdata,
  output logic                          ram_re,
  output logic [ADDR_W-1:0]             ram_raddr,
  input  ppba_pkg::word_t               ram_rdata
);
  import ppba_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int PNUM_W    = ADDR_W + BIT_W;
  localparam int CMP_W     = (PNUM_W + 1 > OS_W) ? PNUM_W + 1 : OS_W;
  localparam int TAIL      = MAX_PAGES % WORD_BITS;
  localparam word_t TAIL_MASK = (TAIL == 0) ? ALL_ONES : ~(ALL_ONES >> TAIL);
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);
  localparam logic [CMP_W-1:0]  MAX_EXT   = CMP_W'(MAX_PAGES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FREE = 5'b00100,
    S_FILL = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic              fill_init, fill_init_next;
  logic [CMP_W-1:0]  reserved, reserved_next;
  logic [BIT_W-1:0]  free_bit, free_bit_next;
  rsp_t              hold_rsp, hold_rsp_next;

  logic [CMP_W-1:0]       page_ext, os_ext, os_sat, last_ext, hit_page;
  logic                   free_ok;
  logic [BIT_W-1:0]       hit_bit;
  logic [CMP_W-BIT_W-1:0] res_word, addr_ext;
  word_t                  fill_word;

  assign page_ext = CMP_W'(req_page);
  assign free_ok  = (req_page != '0) && (page_ext < MAX_EXT);
  assign os_ext   = CMP_W'(os_pages);
  assign os_sat   = (os_ext > MAX_EXT) ? MAX_EXT : os_ext;
  assign last_ext = CMP_W'(last_page);
  assign hit_bit  = first_free(ram_rdata);
  assign hit_page = CMP_W'({addr, hit_bit});
  assign res_word = reserved[CMP_W-1:BIT_W];
  assign addr_ext = (CMP_W - BIT_W)'(addr);

  // Rebuild pattern for the word under the sweep
  always_comb begin
    if (addr_ext < res_word) begin
      fill_word = '0;
    end else if (addr_ext == res_word) begin
      fill_word = ALL_ONES >> reserved[BIT_W-1:0];
    end else begin
      fill_word = ALL_ONES;
    end
    if (addr == LAST_WORD) begin
      fill_word = fill_word & TAIL_MASK;
    end
  end

  assign req_stall = (state != S_IDLE);

  // One request at a time: the write-back lands before the next request can
  // issue its read, so reads and writes to one word never overlap.
  always_comb begin
    state_next     = state;
    addr_next      = addr;
    fill_init_next = fill_init;
    reserved_next  = reserved;
    free_bit_next  = free_bit;
    hold_rsp_next  = hold_rsp;
    fin_valid      = 1'b0;
    fin_rsp        = '{status: STATUS_OK, page: '0};
    ram_we         = 1'b0;
    ram_waddr      = addr;
    ram_wdata      = fill_word;
    ram_re         = 1'b0;
    ram_raddr      = addr;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (op_t'(req_op))
            OP_ALLOC: begin
              ram_re     = 1'b1;
              ram_raddr  = '0;
              addr_next  = '0;
              state_next = S_SCAN;
            end
            OP_FREE: begin
              if (free_ok) begin
                ram_re        = 1'b1;
                ram_raddr     = page_ext[PNUM_W-1:BIT_W];
                addr_next     = page_ext[PNUM_W-1:BIT_W];
                free_bit_next = req_page[BIT_W-1:0];
                state_next    = S_FREE;
              end else begin
                fin_valid = 1'b1;
              end
            end
            OP_INIT: begin
              reserved_next  = os_sat;
              addr_next      = '0;
              fill_init_next = 1'b1;
              state_next     = S_FILL;
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ram_rdata != '0) begin
          fin_valid  = 1'b1;
          state_next = S_IDLE;
          if (hit_page > last_ext) begin
            fin_rsp.status = STATUS_NO_PAGE;
          end else begin
            ram_we       = 1'b1;
            ram_wdata    = ram_rdata & ~(TOP_BIT >> hit_bit);
            fin_rsp.page = hit_page[PAGE_W-1:0];
          end
        end else if (addr == LAST_WORD) begin
          fin_valid      = 1'b1;
          fin_rsp.status = STATUS_NO_PAGE;
          state_next     = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr + 1'b1;
          addr_next = addr + 1'b1;
        end
      end
      S_FREE: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata | (TOP_BIT >> free_bit);
        fin_valid  = 1'b1;
        state_next = S_IDLE;
      end
      S_FILL: begin
        ram_we = 1'b1;
        if (addr == LAST_WORD) begin
          fin_valid      = fill_init;
          fill_init_next = 1'b0;
          state_next     = S_IDLE;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      S_HOLD: begin
        fin_valid = 1'b1;
        fin_rsp   = hold_rsp;
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Park the result while the output register is still full
    if (fin_valid && !slot_free && state != S_HOLD) begin
      hold_rsp_next = fin_rsp;
      state_next    = S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      addr      <= '0;
      fill_init <= 1'b0;
      reserved  <= '0;
    end else begin
      state     <= state_next;
      addr      <= addr_next;
      fill_init <= fill_init_next;
      reserved  <= reserved_next;
    end
  end

  always_ff @(posedge clk) begin
    free_bit <= free_bit_next;
    hold_rsp <= hold_rsp_next;
  end

endmodule

FILE: hw/rtl/physical_page_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// physical_page_bitmap_allocator_top
// First-fit page allocator over a free bitmap held in a word-wide memory.
// ----------------------------------------------------------------------------
// Allocate: scans from word 0 up to the first word with a free bit, one map
//   word read per cycle from the memory, and then loads the result register.
// Free: read word, write back; init: one word written per cycle.
// Ignored requests finish from the idle state without a map access.
// One request in flight; the next is taken while a result waits for rsp_stall.
// Reset: a sweep over all map words marks every page free; req_stall stays high.
module physical_page_bitmap_allocator_top #(
  parameter int MAX_PAGES = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [ppba_pkg::OP_W-1:0]         op,
  input  logic [ppba_pkg::PAGE_W-1:0]       page,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              status,
  output logic [ppba_pkg::PAGE_W-1:0]       granted_page,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppba_pkg::OS_W-1:0]         cfg_data
);
  import ppba_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [OS_W-1:0]   os_pages;
  logic [PAGE_W-1:0] last_page;
  rsp_t              rsp_r;
  logic              slot_free;
  logic              fin_valid;
  rsp_t              fin_rsp;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  word_t             ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      os_pages  <= '0;
      last_page <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OS_PAGES:  os_pages  <= cfg_data;
        CFG_LAST_PAGE: last_page <= cfg_data[PAGE_W-1:0];
        default:       ;
      endcase
    end
  end

  assign slot_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_valid && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && slot_free) begin
      rsp_r <= fin_rsp;
    end
  end

  assign status       = rsp_r.status;
  assign granted_page = rsp_r.page;

  ppba_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_op    (op),
    .req_page  (page),
    .os_pages  (os_pages),
    .last_page (last_page),
    .slot_free (slot_free),
    .fin_valid (fin_valid),
    .fin_rsp   (fin_rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ppba_map_ram #(
    .DEPTH  (MAP_WORDS),
    .ADDR_W (ADDR_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re)
    else $error("map read and write-back in the same cycle");

  a_fail_no_page: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> granted_page == '0)
    else $error("failed allocate carries a page number");

  a_grant_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !status |-> granted_page <= last_page)
    else $error("granted page above last_page");

  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && op == OP_ALLOC |=> req_stall)
    else $error("allocate request did not start a scan");

endmodule
